>>> src/bsc_pkg.sv
// bsc_pkg: shared types, constants and register codes of the barometric
// compensation block. No dependencies; used by front, back, top and checker files.
`default_nettype none

package bsc_pkg;

    localparam int RAW_W           = 24;   // converter sample width
    localparam int CFG_W           = 48;   // widest calibration register
    localparam int CFG_IDX_W       = 2;
    localparam int TEMP_W          = 44;   // linearised temperature, Q32
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int MID_DEPTH_DEF   = 8;
    localparam int OUT_DEPTH_DEF   = 32;

    localparam int TEMP_LOW   = -4000;
    localparam int TEMP_HIGH  = 8500;
    localparam int PRESS_HIGH = 16777215;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_CAL = 2'd0,
        REG_PRESS_A  = 2'd1,
        REG_PRESS_B  = 2'd2,
        REG_PRESS_C  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [39:0] temp;
        logic [47:0] press_a;
        logic [47:0] press_b;
        logic [31:0] press_c;
    } calib_t;

    // front to back: temperature done, pressure still to do
    typedef struct packed {
        logic signed [TEMP_W-1:0] t;
        logic [RAW_W-1:0]         rp;
        logic signed [14:0]       tc;
        logic                     tclip;
    } temp_beat_t;

    typedef struct packed {
        logic signed [14:0] tc;
        logic [23:0]        pc;
        logic               tclip;
        logic               pclip;
    } result_t;

endpackage

`default_nettype wire

>>> src/bsc_mul.sv
// bsc_mul: signed multiplier built from four half-width partial products,
// registered as partial products and then as their sum. Depends on nothing.
`default_nettype none

module bsc_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic                    clk,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);

    localparam int LA = WA / 2;
    localparam int HA = WA - LA;
    localparam int LB = WB / 2;
    localparam int HB = WB - LB;
    localparam int WP = WA + WB;

    logic signed [HA+HB-1:0] hh_reg;
    logic signed [HA+LB:0]   hl_reg;
    logic signed [LA+HB:0]   lh_reg;
    logic [LA+LB-1:0]        ll_reg;
    logic signed [WP-1:0]    p_reg;

    logic signed [WP-1:0] hh_x, hl_x, lh_x, ll_x;

    always_ff @(posedge clk)
    begin
        hh_reg <= $signed(a[WA-1:LA]) * $signed(b[WB-1:LB]);
        hl_reg <= $signed(a[WA-1:LA]) * $signed({1'b0, b[LB-1:0]});
        lh_reg <= $signed({1'b0, a[LA-1:0]}) * $signed(b[WB-1:LB]);
        ll_reg <= a[LA-1:0] * b[LB-1:0];
    end

    assign hh_x = {{(WP-HA-HB){hh_reg[HA+HB-1]}}, hh_reg};
    assign hl_x = {{(WP-HA-LB-1){hl_reg[HA+LB]}}, hl_reg};
    assign lh_x = {{(WP-LA-HB-1){lh_reg[LA+HB]}}, lh_reg};
    assign ll_x = {{(WP-LA-LB){1'b0}}, ll_reg};

    always_ff @(posedge clk)
    begin
        p_reg <= (hh_x <<< (LA + LB)) + (hl_x <<< LA) + (lh_x <<< LB) + ll_x;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> src/bsc_delay.sv
// bsc_delay: fixed-length register line used to align operands in the
// pressure pipeline. Depends on nothing.
`default_nettype none

module bsc_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] line_reg [N];

    always_ff @(posedge clk)
    begin
        line_reg[0] <= d;
        for (int i = 1; i < N; i++)
        begin
            line_reg[i] <= line_reg[i-1];
        end
    end

    assign q = line_reg[N-1];

endmodule

`default_nettype wire

>>> src/bsc_fifo.sv
// bsc_fifo: small register queue, read combinationally at its head.
// Depends on nothing; callers keep it from overflowing by credit.
`default_nettype none

module bsc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  logic [W-1:0] din,
    input  logic         rd,
    output logic [W-1:0] dout,
    output logic         empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_rd;

    assign empty = (cnt_reg == '0);
    assign do_rd = rd && !empty;
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (!wr && do_rd)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> src/bsc_front.sv
// bsc_front: takes sample pairs, linearises temperature (Q32) and rounds
// and clamps the temperature output. Depends on bsc_pkg.
`default_nettype none

module bsc_front #(
    parameter int SAMPLE_BITS = bsc_pkg::SAMPLE_BITS_DEF,
    parameter int MID_DEPTH   = bsc_pkg::MID_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [bsc_pkg::RAW_W-1:0]    raw_temperature,
    input  logic [bsc_pkg::RAW_W-1:0]    raw_pressure,
    input  bsc_pkg::calib_t              calib,
    input  logic                         mid_pop,
    output logic                         beat_valid,
    output bsc_pkg::temp_beat_t          beat
);

    localparam int CW = $clog2(MID_DEPTH + 1);
    localparam logic [bsc_pkg::RAW_W-1:0] SMASK =
        bsc_pkg::RAW_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    logic          accept;
    logic [CW-1:0] cnt_reg;
    logic [4:0]    v_reg;

    logic [bsc_pkg::RAW_W-1:0] rt_s0_reg, rp_s0_reg, rp_s1_reg, rp_s2_reg, rp_s3_reg;
    logic signed [42:0]                rt_dt2_s1_reg;
    logic signed [51:0]                dd_s1_reg;
    logic signed [bsc_pkg::TEMP_W-1:0] t_s2_reg, t_s3_reg;
    logic signed [51:0]                t100_s3_reg;
    bsc_pkg::temp_beat_t               beat_reg;

    logic [15:0]        t1, t2;
    logic signed [7:0]  t3;
    logic signed [25:0] d_c;
    logic signed [60:0] l48_c;
    logic signed [19:0] tcr_c;

    assign t1 = calib.temp[15:0];
    assign t2 = calib.temp[31:16];
    assign t3 = $signed(calib.temp[39:32]);

    assign accept = push && !full;
    assign full   = (cnt_reg == CW'(MID_DEPTH));

    assign d_c   = $signed({2'b00, rt_s0_reg}) - $signed({2'b00, t1, 8'h00});
    assign l48_c = (rt_dt2_s1_reg <<< 18) + dd_s1_reg * t3;
    assign tcr_c = $signed(t100_s3_reg[51:32]);

    // credit: items taken in and not yet handed to the back end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            v_reg   <= '0;
        end
        else
        begin
            v_reg <= {v_reg[3:0], accept};
            if (accept && !mid_pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (!accept && mid_pop)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rt_s0_reg     <= raw_temperature & SMASK;
        rp_s0_reg     <= raw_pressure & SMASK;
        rt_dt2_s1_reg <= d_c * $signed({1'b0, t2});
        dd_s1_reg     <= d_c * d_c;
        rp_s1_reg     <= rp_s0_reg;
        t_s2_reg      <= $signed(l48_c[59:16]);
        rp_s2_reg     <= rp_s1_reg;
        t100_s3_reg   <= t_s2_reg * 8'sd100 + (52'sd1 <<< 31);
        t_s3_reg      <= t_s2_reg;
        rp_s3_reg     <= rp_s2_reg;
        beat_reg.t    <= t_s3_reg;
        beat_reg.rp   <= rp_s3_reg;
        if (tcr_c < bsc_pkg::TEMP_LOW)
        begin
            beat_reg.tc    <= 15'(bsc_pkg::TEMP_LOW);
            beat_reg.tclip <= 1'b1;
        end
        else if (tcr_c > bsc_pkg::TEMP_HIGH)
        begin
            beat_reg.tc    <= 15'(bsc_pkg::TEMP_HIGH);
            beat_reg.tclip <= 1'b1;
        end
        else
        begin
            beat_reg.tc    <= tcr_c[14:0];
            beat_reg.tclip <= 1'b0;
        end
    end

    assign beat_valid = v_reg[4];
    assign beat       = beat_reg;

endmodule

`default_nettype wire

>>> src/bsc_back.sv
// bsc_back: pressure pipeline (offset, sensitivity, square and cube terms),
// rounding and clamping. Depends on bsc_pkg, bsc_mul and bsc_delay.
`default_nettype none

module bsc_back #(
    parameter int OUT_DEPTH = bsc_pkg::OUT_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bsc_pkg::calib_t     calib,
    input  logic                mid_empty,
    input  bsc_pkg::temp_beat_t mid_beat,
    output logic                mid_pop,
    input  logic                out_pop,
    output logic                res_valid,
    output bsc_pkg::result_t    result
);

    localparam int CW = $clog2(OUT_DEPTH + 1);
    localparam int TW = bsc_pkg::TEMP_W;

    logic [CW-1:0] ocnt_reg;
    logic [16:0]   v_reg;

    // calibration fields
    logic signed [16:0] p1m, p2m;
    logic signed [7:0]  p3, p7, p10, p11;
    logic signed [15:0] p9;
    logic [15:0]        p5, p6;
    logic signed [24:0] p8s;
    logic signed [18:0] p4s;

    assign p1m = $signed({calib.press_a[15], calib.press_a[15:0]}) - 17'sd16384;
    assign p2m = $signed({calib.press_a[31], calib.press_a[31:16]}) - 17'sd16384;
    assign p3  = $signed(calib.press_a[39:32]);
    assign p4s = $signed({calib.press_a[47:40], 11'h000});
    assign p5  = calib.press_b[15:0];
    assign p6  = calib.press_b[31:16];
    assign p7  = $signed(calib.press_b[39:32]);
    assign p8s = $signed({calib.press_b[47:40], 17'h00000});
    assign p9  = $signed(calib.press_c[15:0]);
    assign p10 = $signed(calib.press_c[23:16]);
    assign p11 = $signed(calib.press_c[31:24]);

    // stage 0: beat taken from the queue
    logic signed [TW-1:0] t_b0_reg;
    logic [23:0]          rp_b0_reg;
    logic [15:0]          meta_b0_reg;

    assign mid_pop = !mid_empty && (ocnt_reg < CW'(OUT_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocnt_reg <= '0;
            v_reg    <= '0;
        end
        else
        begin
            v_reg <= {v_reg[15:0], mid_pop};
            if (mid_pop && !out_pop)
            begin
                ocnt_reg <= ocnt_reg + CW'(1);
            end
            else if (!mid_pop && out_pop)
            begin
                ocnt_reg <= ocnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_pop)
        begin
            t_b0_reg    <= mid_beat.t;
            rp_b0_reg   <= mid_beat.rp;
            meta_b0_reg <= {mid_beat.tc, mid_beat.tclip};
        end
    end

    // aligned copies
    logic [TW-1:0] t_d3, t_d6;
    logic [23:0]   rp_d9;
    logic [15:0]   meta_d15;

    bsc_delay #(.W(TW), .N(3)) u_t3 (.clk(clk), .d(t_b0_reg), .q(t_d3));
    bsc_delay #(.W(TW), .N(6)) u_t6 (.clk(clk), .d(t_b0_reg), .q(t_d6));
    bsc_delay #(.W(24), .N(9)) u_rp9 (.clk(clk), .d(rp_b0_reg), .q(rp_d9));
    bsc_delay #(.W(16), .N(15)) u_meta (.clk(clk), .d(meta_b0_reg), .q(meta_d15));

    // offset polynomial, Horner over T
    logic signed [68:0] km1;
    logic signed [80:0] km2;
    logic signed [92:0] km3;
    logic signed [36:0] k1_reg;
    logic signed [48:0] k2_reg;
    logic signed [60:0] k3_reg;

    bsc_mul #(.WA(25), .WB(TW)) u_km1 (.clk(clk), .a(p8s), .b(t_b0_reg), .p(km1));
    bsc_mul #(.WA(37), .WB(TW)) u_km2 (.clk(clk), .a(k1_reg), .b($signed(t_d3)), .p(km2));
    bsc_mul #(.WA(49), .WB(TW)) u_km3 (.clk(clk), .a(k2_reg), .b($signed(t_d6)), .p(km3));

    // sensitivity polynomial, then times raw pressure
    logic signed [62:0] hm1;
    logic signed [74:0] hm2;
    logic signed [86:0] hm3;
    logic signed [79:0] hm4;
    logic signed [30:0] h1_reg;
    logic signed [42:0] h2_reg;
    logic signed [54:0] h3_reg;
    logic signed [63:0] h4_reg;

    bsc_mul #(.WA(19), .WB(TW)) u_hm1 (.clk(clk), .a(p4s), .b(t_b0_reg), .p(hm1));
    bsc_mul #(.WA(31), .WB(TW)) u_hm2 (.clk(clk), .a(h1_reg), .b($signed(t_d3)), .p(hm2));
    bsc_mul #(.WA(43), .WB(TW)) u_hm3 (.clk(clk), .a(h2_reg), .b($signed(t_d6)), .p(hm3));
    bsc_mul #(.WA(55), .WB(25)) u_hm4 (
        .clk(clk), .a(h3_reg), .b($signed({1'b0, rp_d9})), .p(hm4));

    // square and cube terms in raw pressure
    logic [47:0]        rpsq_reg;
    logic signed [52:0] coef_reg;
    logic signed [32:0] rpp11_reg;
    logic signed [101:0] sm;
    logic signed [81:0]  cm;
    logic signed [53:0]  sq_reg;
    logic signed [48:0]  cu_reg;

    bsc_mul #(.WA(49), .WB(53)) u_sm (
        .clk(clk), .a($signed({1'b0, rpsq_reg})), .b(coef_reg), .p(sm));
    bsc_mul #(.WA(49), .WB(33)) u_cm (
        .clk(clk), .a($signed({1'b0, rpsq_reg})), .b(rpp11_reg), .p(cm));

    logic [60:0] k3_d3;
    logic [53:0] sq_d8;
    logic [48:0] cu_d8;

    bsc_delay #(.W(61), .N(3)) u_k3 (.clk(clk), .d(k3_reg), .q(k3_d3));
    bsc_delay #(.W(54), .N(8)) u_sq (.clk(clk), .d(sq_reg), .q(sq_d8));
    bsc_delay #(.W(49), .N(8)) u_cu (.clk(clk), .d(cu_reg), .q(cu_d8));

    logic signed [63:0] sa_reg, sb_reg, s_reg;
    logic signed [71:0] x_reg;
    logic signed [39:0] pcr_c;
    bsc_pkg::result_t   res_reg;

    assign pcr_c = $signed(x_reg[71:32]);

    always_ff @(posedge clk)
    begin
        k1_reg    <= $signed(km1[68:32]) + $signed({p7, 24'h000000});
        k2_reg    <= $signed(km2[80:32]) + $signed({1'b0, p6, 26'h0000000});
        k3_reg    <= $signed(km3[92:32]) + $signed({1'b0, p5, 35'h0});
        h1_reg    <= $signed(hm1[62:32]) + $signed({p3, 16'h0000});
        h2_reg    <= $signed(hm2[74:32]) + $signed({p2m, 19'h00000});
        h3_reg    <= $signed(hm3[86:32]) + $signed({p1m, 28'h0000000});
        h4_reg    <= $signed(hm4[79:16]);
        rpsq_reg  <= rp_b0_reg * rp_b0_reg;
        coef_reg  <= $signed({p9, 32'h00000000}) + p10 * t_b0_reg;
        rpp11_reg <= $signed({1'b0, rp_b0_reg}) * p11;
        sq_reg    <= $signed(sm[101:48]);
        cu_reg    <= $signed(cm[81:33]);
        sa_reg    <= h4_reg + $signed(k3_d3);
        sb_reg    <= $signed(sq_d8) + $signed(cu_d8);
        s_reg     <= sa_reg + sb_reg;
        x_reg     <= s_reg * 8'sd100 + (72'sd1 <<< 31);
        res_reg.tc    <= $signed(meta_d15[15:1]);
        res_reg.tclip <= meta_d15[0];
        if (pcr_c < 0)
        begin
            res_reg.pc    <= '0;
            res_reg.pclip <= 1'b1;
        end
        else if (pcr_c > bsc_pkg::PRESS_HIGH)
        begin
            res_reg.pc    <= 24'(bsc_pkg::PRESS_HIGH);
            res_reg.pclip <= 1'b1;
        end
        else
        begin
            res_reg.pc    <= pcr_c[23:0];
            res_reg.pclip <= 1'b0;
        end
    end

    assign res_valid = v_reg[16];
    assign result    = res_reg;

endmodule

`default_nettype wire

>>> src/baro_sensor_compensation.sv
// baro_sensor_compensation: top level of the barometric compensation block.
// Depends on bsc_pkg, bsc_front, bsc_back and bsc_fifo.
//
// Converts one raw temperature / raw pressure sample pair per beat into a
// temperature in 0.01 degC and a pressure in 0.01 Pa, both rounded half up
// and clamped, with a clip flag for each. Both sides look like queues: push
// a pair while full is low, pop a result while empty is low. One pair is
// taken every clock for as long as results are drained; each result goes
// through the front end, the middle queue and the pressure path to the head
// of the output queue; the pressure path has three Horner steps of pipelined
// multipliers, then the final scaling by raw pressure, sum and round. The
// front end (temperature) feeds an 8-entry queue and the back end (pressure)
// a 32-entry result queue; both are guarded by credit counters, so full
// rises only when results are not being popped. Calibration registers are
// written through cfg_we / cfg_index / cfg_data, index 0 temperature word,
// 1..3 pressure words, all reset to zero; write them only while the block
// holds no beats in flight. Only the low SAMPLE_BITS bits of each sample are
// used.
`default_nettype none

module baro_sensor_compensation #(
    parameter int SAMPLE_BITS = bsc_pkg::SAMPLE_BITS_DEF,
    parameter int MID_DEPTH   = bsc_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH   = bsc_pkg::OUT_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsc_pkg::CFG_W-1:0]       cfg_data,
    // sample input
    input  logic                            push,
    output logic                            full,
    input  logic [bsc_pkg::RAW_W-1:0]       raw_temperature,
    input  logic [bsc_pkg::RAW_W-1:0]       raw_pressure,
    // results
    output logic                            empty,
    input  logic                            pop,
    output logic signed [14:0]              temperature_centi,
    output logic [23:0]                     pressure_centi,
    output logic                            temp_clipped,
    output logic                            press_clipped
);

    localparam int BEAT_W = $bits(bsc_pkg::temp_beat_t);
    localparam int RES_W  = $bits(bsc_pkg::result_t);

    // calibration words, held exactly as the sensor stores them
    bsc_pkg::calib_t calib_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (bsc_pkg::reg_index_t'(cfg_index))
                bsc_pkg::REG_TEMP_CAL: calib_reg.temp    <= cfg_data[39:0];
                bsc_pkg::REG_PRESS_A:  calib_reg.press_a <= cfg_data[47:0];
                bsc_pkg::REG_PRESS_B:  calib_reg.press_b <= cfg_data[47:0];
                bsc_pkg::REG_PRESS_C:  calib_reg.press_c <= cfg_data[31:0];
            endcase
        end
    end

    // front end: temperature
    logic                beat_valid;
    bsc_pkg::temp_beat_t beat;
    logic                mid_pop;
    logic                mid_empty;
    logic [BEAT_W-1:0]   mid_dout;
    bsc_pkg::temp_beat_t mid_head;

    bsc_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MID_DEPTH   (MID_DEPTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .raw_temperature (raw_temperature),
        .raw_pressure    (raw_pressure),
        .calib           (calib_reg),
        .mid_pop         (mid_pop),
        .beat_valid      (beat_valid),
        .beat            (beat)
    );

    // decoupling queue between the two halves
    bsc_fifo #(
        .W     (BEAT_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (beat_valid),
        .din   (beat),
        .rd    (mid_pop),
        .dout  (mid_dout),
        .empty (mid_empty)
    );

    assign mid_head = mid_dout;

    // back end: pressure
    logic              out_pop;
    logic              res_valid;
    bsc_pkg::result_t  result;
    logic [RES_W-1:0]  out_dout;
    bsc_pkg::result_t  out_head;

    assign out_pop = pop && !empty;

    bsc_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .calib     (calib_reg),
        .mid_empty (mid_empty),
        .mid_beat  (mid_head),
        .mid_pop   (mid_pop),
        .out_pop   (out_pop),
        .res_valid (res_valid),
        .result    (result)
    );

    // result queue; the back end never overruns it thanks to its credit count
    bsc_fifo #(
        .W     (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_valid),
        .din   (result),
        .rd    (pop),
        .dout  (out_dout),
        .empty (empty)
    );

    assign out_head          = out_dout;
    assign temperature_centi = out_head.tc;
    assign pressure_centi    = out_head.pc;
    assign temp_clipped      = out_head.tclip;
    assign press_clipped     = out_head.pclip;

endmodule

`default_nettype wire

>>> src/bsc_checker.sv
// bsc_checker: port-level assertions for baro_sensor_compensation, bound to
// the top level below. Depends on bsc_pkg.
`default_nettype none

module bsc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic signed [14:0] temperature_centi,
    input logic [23:0]        pressure_centi,
    input logic               temp_clipped,
    input logic               press_clipped
);

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (temperature_centi >= bsc_pkg::TEMP_LOW &&
                    temperature_centi <= bsc_pkg::TEMP_HIGH))
        else $error("temperature outside clamp range");

    a_temp_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && temp_clipped) |->
            (temperature_centi == bsc_pkg::TEMP_LOW ||
             temperature_centi == bsc_pkg::TEMP_HIGH))
        else $error("temperature clip flag without a bound value");

    a_press_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && press_clipped) |->
            (pressure_centi == 24'd0 || pressure_centi == 24'(bsc_pkg::PRESS_HIGH)))
        else $error("pressure clip flag without a bound value");

    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pressure_centi) &&
                              $stable(temperature_centi)))
        else $error("result head changed while not popped");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .empty             (empty),
    .pop               (pop),
    .temperature_centi (temperature_centi),
    .pressure_centi    (pressure_centi),
    .temp_clipped      (temp_clipped),
    .press_clipped     (press_clipped)
);

`default_nettype wire
